@@ rtl/e2dv_pkg.sv @@
`timescale 1ns / 1ps
// e2dv_pkg: types, constants and per-cell divisor tables for the pose converter
// no dependencies; imported by every module of the block
package e2dv_pkg;

  // pipeline depths
  localparam int NCELL    = 4;
  localparam int LAT_SC   = 23;
  localparam int LAT_MUL  = 3;
  localparam int LAT_PIPE = LAT_SC + LAT_MUL;
  localparam int MET_CORE = 6;
  localparam int MET_PAD  = LAT_PIPE - MET_CORE;

  // angle limits and split points, 1/64 degree
  localparam logic signed [15:0] ANG_MAX     = 16'sd23040;
  localparam logic signed [15:0] ANG_MIN     = -16'sd23040;
  localparam logic signed [16:0] ANG_FULL_S  = 17'sd23040;
  localparam logic        [14:0] ANG_Q1      = 15'd5760;
  localparam logic        [14:0] ANG_Q2      = 15'd11520;
  localparam logic        [14:0] ANG_Q3      = 15'd17280;
  localparam logic        [12:0] ANG_QUARTER = 13'd5760;
  localparam logic        [12:0] ANG_EIGHTH  = 13'd2880;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // series arithmetic, unsigned q30
  localparam logic [18:0] RAD_Q30     = 19'd292818;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [30:0] HALF_LSB_14 = 31'h0000_8000;

  localparam logic [31:0] RCP_42 = 32'(64'hFFFF_FFFF / 64'd42);
  localparam logic [31:0] RCP_20 = 32'(64'hFFFF_FFFF / 64'd20);
  localparam logic [31:0] RCP_6  = 32'(64'hFFFF_FFFF / 64'd6);
  localparam logic [31:0] RCP_1  = 32'(64'hFFFF_FFFF / 64'd1);
  localparam logic [31:0] RCP_56 = 32'(64'hFFFF_FFFF / 64'd56);
  localparam logic [31:0] RCP_30 = 32'(64'hFFFF_FFFF / 64'd30);
  localparam logic [31:0] RCP_12 = 32'(64'hFFFF_FFFF / 64'd12);
  localparam logic [31:0] RCP_2  = 32'(64'hFFFF_FFFF / 64'd2);

  localparam logic [5:0]  SIN_DIV [NCELL] = '{6'd42, 6'd20, 6'd6, 6'd1};
  localparam logic [31:0] SIN_RCP [NCELL] = '{RCP_42, RCP_20, RCP_6, RCP_1};
  localparam logic [5:0]  COS_DIV [NCELL] = '{6'd56, 6'd30, 6'd12, 6'd2};
  localparam logic [31:0] COS_RCP [NCELL] = '{RCP_56, RCP_30, RCP_12, RCP_2};

  // inches to metres: round(p * 200 / 7874) == floor((p * 100 + 1968) / 3937)
  localparam logic [37:0] MET_SCALE = 38'd100;
  localparam logic [37:0] MET_BIAS  = 38'd1968;
  localparam logic [11:0] MET_DIV   = 12'd3937;
  localparam logic [26:0] MET_RCP   = 27'((64'd1 << 38) / 64'd3937);

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [1:0]  quad;
    logic        swap;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic [30:0] ts;
    logic [30:0] tc;
  } cell_t;

endpackage

@@ rtl/euler_angles_to_direction_vectors.sv @@
`timescale 1ns / 1ps
// euler_angles_to_direction_vectors: pose converter, position to metres, angles to
// front and top vectors; depends on e2dv_pkg, e2dv_sincos, e2dv_metres, e2dv_mul
//
// input channel: in_valid / in_stall with the position in inches (q16.16) and two
// angles in 1/64 degree; a transfer happens on a clock edge with in_valid high and
// in_stall low. output channel: out_valid / out_stall with one result per input.
// each angle runs through its own sine/cosine pipe: wrap, octant fold, then a row
// of four horner cells of four stages each; metres use a reciprocal multiply.
// throughput: one item per cycle while the output is taken.
// angles outside plus or minus 360 degrees give an all-zero result, valid_res too.
// reset (rst, synchronous) empties the pipe and the output stage; nothing else.
// when the receiver stalls, the held result stays stable, one more result lands in
// a skid register, and then in_stall rises and the whole pipe holds until the skid
// register drains.
module euler_angles_to_direction_vectors (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pos_x_inch,
  input  logic signed [31:0] pos_y_inch,
  input  logic signed [31:0] pos_z_inch,
  input  logic signed [15:0] tilt_angle,
  input  logic signed [15:0] turn_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               valid_res,
  output logic signed [31:0] out_x_m,
  output logic signed [31:0] out_y_m,
  output logic signed [31:0] out_z_m,
  output logic signed [15:0] front_x,
  output logic signed [15:0] front_y,
  output logic signed [15:0] front_z,
  output logic signed [15:0] top_x,
  output logic signed [15:0] top_y,
  output logic signed [15:0] top_z
);
  import e2dv_pkg::*;

  typedef struct packed {
    logic               valid_res;
    logic signed [31:0] out_x_m;
    logic signed [31:0] out_y_m;
    logic signed [31:0] out_z_m;
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
    logic signed [15:0] top_x;
    logic signed [15:0] top_y;
    logic signed [15:0] top_z;
  } res_t;

  logic en, take, new_item, ok_in;
  logic vcap, okcap;
  logic signed [31:0] px, py, pz;
  logic signed [15:0] h, v;
  logic [LAT_PIPE-1:0] vpipe, okpipe;
  logic signed [15:0] sh, ch, sv, cv;
  logic signed [15:0] sh_d [LAT_MUL];
  logic signed [15:0] ch_d [LAT_MUL];
  logic signed [31:0] mx, my, mz;
  logic signed [15:0] fx, fz, tx, tz;
  logic okl;
  res_t pd, out_d, skid_d;
  logic skid_vld;

  assign en       = ~skid_vld;
  assign in_stall = skid_vld;
  assign take     = out_valid & ~out_stall;
  assign new_item = en & vpipe[LAT_PIPE-1];
  assign ok_in    = (tilt_angle >= ANG_MIN) && (tilt_angle <= ANG_MAX) &&
                    (turn_angle >= ANG_MIN) && (turn_angle <= ANG_MAX);

  // input capture
  always_ff @(posedge clk) begin
    if (rst) begin
      vcap  <= 1'b0;
      vpipe <= '0;
    end else if (en) begin
      vcap  <= in_valid;
      vpipe <= {vpipe[LAT_PIPE-2:0], vcap};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      okcap  <= ok_in;
      okpipe <= {okpipe[LAT_PIPE-2:0], okcap};
      px     <= pos_x_inch;
      py     <= pos_y_inch;
      pz     <= pos_z_inch;
      h      <= tilt_angle;
      v      <= turn_angle;
    end
  end

  e2dv_sincos u_sc_h (.clk(clk), .en(en), .angle(h), .sin_q14(sh), .cos_q14(ch));
  e2dv_sincos u_sc_v (.clk(clk), .en(en), .angle(v), .sin_q14(sv), .cos_q14(cv));

  e2dv_metres u_met_x (.clk(clk), .en(en), .inch(px), .metre(mx));
  e2dv_metres u_met_y (.clk(clk), .en(en), .inch(pz), .metre(my));
  e2dv_metres u_met_z (.clk(clk), .en(en), .inch(py), .metre(mz));

  e2dv_mul u_mul_fx (.clk(clk), .en(en), .a(cv), .b(ch), .p(fx));
  e2dv_mul u_mul_fz (.clk(clk), .en(en), .a(sv), .b(ch), .p(fz));
  e2dv_mul u_mul_tx (.clk(clk), .en(en), .a(cv), .b(sh), .p(tx));
  e2dv_mul u_mul_tz (.clk(clk), .en(en), .a(sv), .b(sh), .p(tz));

  always_ff @(posedge clk) begin
    if (en) begin
      sh_d[0] <= sh;
      ch_d[0] <= ch;
      for (int i = 1; i < LAT_MUL; i++) begin
        sh_d[i] <= sh_d[i-1];
        ch_d[i] <= ch_d[i-1];
      end
    end
  end

  // out-of-range angles clear the whole result
  assign okl = okpipe[LAT_PIPE-1];

  always_comb begin
    pd.valid_res = okl;
    pd.out_x_m   = okl ? mx : '0;
    pd.out_y_m   = okl ? my : '0;
    pd.out_z_m   = okl ? mz : '0;
    pd.front_x   = okl ? fx : '0;
    pd.front_y   = okl ? 16'(-sh_d[LAT_MUL-1]) : '0;
    pd.front_z   = okl ? fz : '0;
    pd.top_x     = okl ? tx : '0;
    pd.top_y     = okl ? ch_d[LAT_MUL-1] : '0;
    pd.top_z     = okl ? tz : '0;
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (skid_vld) begin
      if (take) begin
        skid_vld <= 1'b0;
      end
    end else if (!out_valid || take) begin
      out_valid <= new_item;
    end else if (new_item) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (take) begin
        out_d <= skid_d;
      end
    end else if (!out_valid || take) begin
      out_d <= pd;
    end else if (new_item) begin
      skid_d <= pd;
    end
  end

  assign valid_res = out_d.valid_res;
  assign out_x_m   = out_d.out_x_m;
  assign out_y_m   = out_d.out_y_m;
  assign out_z_m   = out_d.out_z_m;
  assign front_x   = out_d.front_x;
  assign front_y   = out_d.front_y;
  assign front_z   = out_d.front_z;
  assign top_x     = out_d.top_x;
  assign top_y     = out_d.top_y;
  assign top_z     = out_d.top_z;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_valid)
    else $error("skid register full while output register empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_vld) |-> $past(out_valid && out_stall))
    else $error("skid register filled without a stalled output");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !valid_res) |-> (out_x_m == 0 && out_z_m == 0 && front_x == 0 &&
                                   top_y == 0 && top_z == 0))
    else $error("out-of-range result carries nonzero fields");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (top_y <= 16'sd16384 && top_y >= -16'sd16384 &&
                   front_y <= 16'sd16384 && front_y >= -16'sd16384))
    else $error("vector component outside unit range");

endmodule

@@ rtl/e2dv_cell.sv @@
`timescale 1ns / 1ps
// e2dv_cell: one horner step t = 1 - ((m * t) >> 30) / k for a sine and a cosine lane
// four register stages; depends on e2dv_pkg
module e2dv_cell (
  input  logic            clk,
  input  logic            en,
  input  logic            use_x,
  input  logic [5:0]      sin_div,
  input  logic [31:0]     sin_rcp,
  input  logic [5:0]      cos_div,
  input  logic [31:0]     cos_rcp,
  input  e2dv_pkg::cell_t din,
  output e2dv_pkg::cell_t dout
);
  import e2dv_pkg::*;

  logic [29:0] sin_op;
  logic [60:0] ps_prod, pc_prod;
  logic [61:0] rs_prod, rc_prod;
  logic [35:0] ks_prod, kc_prod;
  logic [29:0] rem_s, rem_c;

  tag_t        tag1, tag2, tag3;
  logic [29:0] ns1, nc1, ns2, nc2, qs2, qc2, qs3, qc3;
  logic        gs3, gc3;

  assign sin_op  = use_x ? din.tag.x : din.tag.x2;
  assign ps_prod = {31'd0, sin_op} * {30'd0, din.ts};
  assign pc_prod = {31'd0, din.tag.x2} * {30'd0, din.tc};
  assign rs_prod = {32'd0, ns1} * {30'd0, sin_rcp};
  assign rc_prod = {32'd0, nc1} * {30'd0, cos_rcp};
  assign ks_prod = {6'd0, qs2} * {30'd0, sin_div};
  assign kc_prod = {6'd0, qc2} * {30'd0, cos_div};
  assign rem_s   = ns2 - ks_prod[29:0];
  assign rem_c   = nc2 - kc_prod[29:0];

  always_ff @(posedge clk) begin
    if (en) begin
      // product
      tag1 <= din.tag;
      ns1  <= ps_prod[59:30];
      nc1  <= pc_prod[59:30];
      // quotient estimate
      tag2 <= tag1;
      ns2  <= ns1;
      nc2  <= nc1;
      qs2  <= rs_prod[61:32];
      qc2  <= rc_prod[61:32];
      // correction
      tag3 <= tag2;
      qs3  <= qs2;
      qc3  <= qc2;
      gs3  <= (rem_s >= {24'd0, sin_div});
      gc3  <= (rem_c >= {24'd0, cos_div});
      // next term
      dout.tag <= tag3;
      dout.ts  <= ONE_Q30 - ({1'b0, qs3} + {30'd0, gs3});
      dout.tc  <= ONE_Q30 - ({1'b0, qc3} + {30'd0, gc3});
    end
  end

endmodule

@@ rtl/e2dv_sincos.sv @@
`timescale 1ns / 1ps
// e2dv_sincos: angle wrap, octant fold, row of horner cells and quadrant mapping
// 23 register stages; depends on e2dv_pkg and e2dv_cell
module e2dv_sincos (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] angle,
  output logic signed [15:0] sin_q14,
  output logic signed [15:0] cos_q14
);
  import e2dv_pkg::*;

  logic signed [16:0] a_ext, a_pos, a_wrap;
  logic [14:0] aw1;
  logic [1:0]  q_n;
  logic [14:0] base_n;
  logic [12:0] r2;
  logic [1:0]  quad2, quad3, quad4;
  logic [11:0] u3;
  logic        sw3, sw4;
  logic [30:0] x_prod;
  logic [29:0] x4;
  logic [59:0] x2_prod;
  tag_t        tag5;
  cell_t       link [NCELL+1];
  logic [30:0] s_val, s_sum, c_sum;
  logic [14:0] sq6, cq6, rs, rc;
  logic [1:0]  quad6;
  logic        sw6;
  logic signed [15:0] s_pos, c_pos, s_n, c_n;

  // wrap into 0 .. full turn - 1
  always_comb begin
    a_ext  = {angle[15], angle};
    a_pos  = (a_ext < 0) ? a_ext + ANG_FULL_S : a_ext;
    a_wrap = (a_pos >= ANG_FULL_S) ? a_pos - ANG_FULL_S : a_pos;
  end

  always_comb begin
    if (aw1 >= ANG_Q3) begin
      q_n = QUAD_3;
      base_n = ANG_Q3;
    end else if (aw1 >= ANG_Q2) begin
      q_n = QUAD_2;
      base_n = ANG_Q2;
    end else if (aw1 >= ANG_Q1) begin
      q_n = QUAD_1;
      base_n = ANG_Q1;
    end else begin
      q_n = QUAD_0;
      base_n = 15'd0;
    end
  end

  assign x_prod  = {19'd0, u3} * {12'd0, RAD_Q30};
  assign x2_prod = {30'd0, x4} * {30'd0, x4};

  always_ff @(posedge clk) begin
    if (en) begin
      aw1   <= a_wrap[14:0];
      quad2 <= q_n;
      r2    <= 13'(aw1 - base_n);
      quad3 <= quad2;
      if (r2 <= ANG_EIGHTH) begin
        u3  <= r2[11:0];
        sw3 <= 1'b0;
      end else begin
        u3  <= 12'(ANG_QUARTER - r2);
        sw3 <= 1'b1;
      end
      x4        <= x_prod[29:0];
      quad4     <= quad3;
      sw4       <= sw3;
      tag5.x    <= x4;
      tag5.x2   <= x2_prod[59:30];
      tag5.quad <= quad4;
      tag5.swap <= sw4;
    end
  end

  assign link[0] = '{tag: tag5, ts: ONE_Q30, tc: ONE_Q30};

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    e2dv_cell u_cell (
      .clk     (clk),
      .en      (en),
      .use_x   (i == NCELL - 1),
      .sin_div (SIN_DIV[i]),
      .sin_rcp (SIN_RCP[i]),
      .cos_div (COS_DIV[i]),
      .cos_rcp (COS_RCP[i]),
      .din     (link[i]),
      .dout    (link[i+1])
    );
  end

  // last sine cell leaves 1 - x * t
  assign s_val = ONE_Q30 - link[NCELL].ts;
  assign s_sum = s_val + HALF_LSB_14;
  assign c_sum = link[NCELL].tc + HALF_LSB_14;

  always_comb begin
    rs    = sw6 ? cq6 : sq6;
    rc    = sw6 ? sq6 : cq6;
    s_pos = {1'b0, rs};
    c_pos = {1'b0, rc};
    case (quad6)
      QUAD_0: begin
        s_n = s_pos;
        c_n = c_pos;
      end
      QUAD_1: begin
        s_n = c_pos;
        c_n = -s_pos;
      end
      QUAD_2: begin
        s_n = -s_pos;
        c_n = -c_pos;
      end
      default: begin
        s_n = -c_pos;
        c_n = s_pos;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq6     <= s_sum[30:16];
      cq6     <= c_sum[30:16];
      quad6   <= link[NCELL].tag.quad;
      sw6     <= link[NCELL].tag.swap;
      sin_q14 <= s_n;
      cos_q14 <= c_n;
    end
  end

endmodule

@@ rtl/e2dv_metres.sv @@
`timescale 1ns / 1ps
// e2dv_metres: inches to metres, rounded to nearest with ties away from zero
// reciprocal multiply with one correction step, padded to the angle path depth; uses e2dv_pkg
module e2dv_metres (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] inch,
  output logic signed [31:0] metre
);
  import e2dv_pkg::*;

  logic        neg1, neg2, neg3, neg4, neg5;
  logic [31:0] mag1;
  logic [37:0] a2, a3, a4;
  logic [45:0] plo, phi, plo3, phi3;
  logic [64:0] sum4;
  logic [26:0] q0_4, q0_5;
  logic [37:0] kq, diff;
  logic [13:0] rem;
  logic        ge5;
  logic [31:0] q6;
  logic [31:0] res6;
  logic [31:0] pad [MET_PAD];

  assign plo  = {19'd0, a2[18:0]} * {19'd0, MET_RCP};
  assign phi  = {19'd0, a2[37:19]} * {19'd0, MET_RCP};
  assign sum4 = {phi3, 19'd0} + {19'd0, plo3};
  assign kq   = {11'd0, q0_4} * {26'd0, MET_DIV};
  assign diff = a4 - kq;
  assign rem  = diff[13:0];
  assign q6   = {5'd0, q0_5} + {31'd0, ge5};

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= inch[31];
      mag1 <= inch[31] ? 32'(-inch) : 32'(inch);
      neg2 <= neg1;
      a2   <= {6'd0, mag1} * MET_SCALE + MET_BIAS;
      neg3 <= neg2;
      a3   <= a2;
      plo3 <= plo;
      phi3 <= phi;
      neg4 <= neg3;
      a4   <= a3;
      q0_4 <= sum4[64:38];
      neg5 <= neg4;
      q0_5 <= q0_4;
      ge5  <= (rem >= {2'd0, MET_DIV});
      res6 <= neg5 ? -q6 : q6;
      pad[0] <= res6;
      for (int i = 1; i < MET_PAD; i++) begin
        pad[i] <= pad[i-1];
      end
    end
  end

  assign metre = pad[MET_PAD-1];

endmodule

@@ rtl/e2dv_mul.sv @@
`timescale 1ns / 1ps
// e2dv_mul: q2.14 product rounded on its magnitude, ties away from zero
// three register stages; depends on e2dv_pkg
module e2dv_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  output logic signed [15:0] p
);
  import e2dv_pkg::*;

  logic        neg1, neg2;
  logic [14:0] ma1, mb1, m2;
  logic [29:0] prod;
  logic [30:0] rnd;

  assign prod = {15'd0, ma1} * {15'd0, mb1};
  assign rnd  = {1'b0, prod} + 31'd8192;

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= a[15] ^ b[15];
      ma1  <= a[15] ? 15'(-a) : a[14:0];
      mb1  <= b[15] ? 15'(-b) : b[14:0];
      neg2 <= neg1;
      m2   <= rnd[28:14];
      p    <= neg2 ? 16'(-{1'b0, m2}) : {1'b0, m2};
    end
  end

endmodule
